// ===== rtl/bprq_pkg.sv =====
// ----------------------------------------------------------------------------
// bprq_pkg
// Shared sizes, codes, entry types and helpers of the bitmap run queue.
// ----------------------------------------------------------------------------
package bprq_pkg;

  localparam int TASK_SLOTS  = 64;
  localparam int PRIO_LEVELS = 256;

  // Slot pointers carry one extra code for the empty mark.
  localparam int PTR_W   = $clog2(TASK_SLOTS + 1);
  localparam int SLOT_AW = $clog2(TASK_SLOTS);
  localparam int LVL_AW  = $clog2(PRIO_LEVELS);
  localparam int STEP_W  = $clog2(TASK_SLOTS + 1);

  localparam int MASK_WORD_W = 64;
  localparam int WORD_POS_W  = 6;
  localparam int MASK_WORDS  = (PRIO_LEVELS + MASK_WORD_W - 1) / MASK_WORD_W;
  localparam int MASK_BITS   = MASK_WORDS * MASK_WORD_W;
  localparam int WORD_W      = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

  localparam int TASK_INDEX_W   = 6;
  localparam int PRIORITY_REQ_W = 8;

  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(TASK_SLOTS);

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_REM  = 2'd1,
    REQ_DEQ  = 2'd2,
    REQ_PEEK = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_e;

  // One level table entry: list head and tail.
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
  } lvl_ent_t;

  localparam int LVL_ENT_W = $bits(lvl_ent_t);

  // Position of the highest set bit of a mask word.
  function automatic logic [WORD_POS_W-1:0] msb_pos(input logic [MASK_WORD_W-1:0] word);
    logic [WORD_POS_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < MASK_WORD_W; i++) begin
      if (word[i]) begin
        pos = WORD_POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/bprq_ram.sv =====
// ----------------------------------------------------------------------------
// bprq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Read returns the old word on a same-address write.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bitmap_priority_run_queue.sv =====
// ----------------------------------------------------------------------------
// bitmap_priority_run_queue
// Ready queue of task slots over priority levels, one FIFO list per level.
// The level heads and tails sit in one RAM and the per-slot links in a
// second RAM, both with registered read data; per-entry valid bits make
// every entry read as empty after reset, so no clearing pass is needed. One
// request is worked at a time and every request gives one result word. An
// enqueue, or a request rejected at the check, reads the level entry and then
// writes its result. Peek and dequeue scan the 64-bit occupancy words from
// the top, 1 to 4 of them, to find the highest level; dequeue then reads
// the level entry and the link of the head slot (a stale level mark ends it
// as empty). Remove walks the level list through the link RAM, passing at
// most 64 elements ahead of the slot. A new request is accepted while the
// last result still waits at the output register.
// ----------------------------------------------------------------------------
module bitmap_priority_run_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [5:0] task_index_i,
  input  logic [7:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [5:0] picked_index_o,
  output logic [7:0] top_priority_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_HT       = 9'b000000010,
    S_WALK_CHK = 9'b000000100,
    S_WALK_RD  = 9'b000001000,
    S_RM_NXT   = 9'b000010000,
    S_SRCH     = 9'b000100000,
    S_DQ_HT    = 9'b001000000,
    S_DQ_NXT   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  bprq_pkg::req_e req_q, req_d;
  logic [bprq_pkg::TASK_INDEX_W-1:0]   idx_q, idx_d;
  logic [bprq_pkg::PRIORITY_REQ_W-1:0] lvl_q, lvl_d;
  logic [bprq_pkg::PTR_W-1:0]  head_q, head_d;
  logic [bprq_pkg::PTR_W-1:0]  tail_q, tail_d;
  logic [bprq_pkg::PTR_W-1:0]  cur_q, cur_d;
  logic [bprq_pkg::PTR_W-1:0]  prev_q, prev_d;
  logic [bprq_pkg::STEP_W-1:0] steps_q, steps_d;
  logic [bprq_pkg::WORD_W-1:0] w_q, w_d;
  logic [bprq_pkg::LVL_AW-1:0] best_q, best_d;

  bprq_pkg::status_e res_status_q, res_status_d;
  logic [bprq_pkg::TASK_INDEX_W-1:0]   res_picked_q, res_picked_d;
  logic [bprq_pkg::PRIORITY_REQ_W-1:0] res_top_q, res_top_d;

  logic                                out_valid_q, out_valid_d;
  bprq_pkg::status_e                   out_status_q;
  logic [bprq_pkg::TASK_INDEX_W-1:0]   out_picked_q;
  logic [bprq_pkg::PRIORITY_REQ_W-1:0] out_top_q;
  logic                                out_load;

  logic [bprq_pkg::PRIO_LEVELS-1:0] lvl_vld_q;
  logic [bprq_pkg::TASK_SLOTS-1:0]  nxt_vld_q, nxt_vld_d;
  logic [bprq_pkg::TASK_SLOTS-1:0]  queued_q;
  logic [bprq_pkg::MASK_BITS-1:0]   mask_q;

  // Level table port signals
  logic                           lwr_en;
  logic [bprq_pkg::LVL_AW-1:0]    lwr_addr;
  bprq_pkg::lvl_ent_t             lwr_ent;
  logic [bprq_pkg::LVL_AW-1:0]    lrd_addr, lrd_addr_q;
  logic [bprq_pkg::LVL_ENT_W-1:0] lrd_data;
  logic                           lvl_clr_en;
  bprq_pkg::lvl_ent_t             ht_eff;

  // Link table port signals
  logic                         nwr_en;
  logic [bprq_pkg::SLOT_AW-1:0] nwr_addr;
  logic [bprq_pkg::PTR_W-1:0]   nwr_data;
  logic [bprq_pkg::SLOT_AW-1:0] nrd_addr, nrd_addr_q;
  logic [bprq_pkg::PTR_W-1:0]   nrd_data;
  logic                         nclr_en;
  logic [bprq_pkg::SLOT_AW-1:0] nclr_addr;
  logic [bprq_pkg::PTR_W-1:0]   nxt_eff;

  // Flag updates
  logic                         q_set_en, q_clr_en;
  logic [bprq_pkg::SLOT_AW-1:0] q_addr;
  logic                         mask_set_en, mask_clr_en;
  logic [bprq_pkg::LVL_AW-1:0]  mask_addr;

  logic                          in_accept;
  logic                          bad_req;
  logic [bprq_pkg::PTR_W-1:0]    idx_ptr;
  logic [bprq_pkg::SLOT_AW-1:0]  idx_slot;
  logic [bprq_pkg::LVL_AW-1:0]   lvl_addr;
  logic [bprq_pkg::MASK_WORD_W-1:0] scan_word;
  logic [bprq_pkg::LVL_AW-1:0]   scan_lvl;
  logic [bprq_pkg::PTR_W-1:0]    new_head;

  bprq_ram #(
    .WIDTH (bprq_pkg::LVL_ENT_W),
    .DEPTH (bprq_pkg::PRIO_LEVELS)
  ) u_lvl_ram (
    .clk_i     (clk_i),
    .wr_en_i   (lwr_en),
    .wr_addr_i (lwr_addr),
    .wr_data_i (lwr_ent),
    .rd_addr_i (lrd_addr),
    .rd_data_o (lrd_data)
  );

  bprq_ram #(
    .WIDTH (bprq_pkg::PTR_W),
    .DEPTH (bprq_pkg::TASK_SLOTS)
  ) u_nxt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (nwr_en),
    .wr_addr_i (nwr_addr),
    .wr_data_i (nwr_data),
    .rd_addr_i (nrd_addr),
    .rd_data_o (nrd_data)
  );

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign idx_ptr  = bprq_pkg::PTR_W'(idx_q);
  assign idx_slot = bprq_pkg::SLOT_AW'(idx_q);
  assign lvl_addr = bprq_pkg::LVL_AW'(lvl_q);
  assign bad_req  = (int'(idx_q) >= bprq_pkg::TASK_SLOTS) ||
                    (int'(lvl_q) >= bprq_pkg::PRIO_LEVELS);

  // Entries never written read as empty.
  assign ht_eff  = lvl_vld_q[lrd_addr_q] ? bprq_pkg::lvl_ent_t'(lrd_data) :
                   bprq_pkg::lvl_ent_t'{head: bprq_pkg::NIL_PTR, tail: bprq_pkg::NIL_PTR};
  assign nxt_eff = nxt_vld_q[nrd_addr_q] ? nrd_data : bprq_pkg::NIL_PTR;

  assign scan_word = mask_q[int'(w_q) * bprq_pkg::MASK_WORD_W +: bprq_pkg::MASK_WORD_W];
  assign scan_lvl  = bprq_pkg::LVL_AW'(int'(w_q) * bprq_pkg::MASK_WORD_W +
                                       int'(bprq_pkg::msb_pos(scan_word)));

  assign new_head = (prev_q == bprq_pkg::NIL_PTR) ? nxt_eff : head_q;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    idx_d        = idx_q;
    lvl_d        = lvl_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    steps_d      = steps_q;
    w_d          = w_q;
    best_d       = best_q;
    res_status_d = res_status_q;
    res_picked_d = res_picked_q;
    res_top_d    = res_top_q;

    lrd_addr    = lrd_addr_q;
    lwr_en      = 1'b0;
    lwr_addr    = lvl_addr;
    lwr_ent     = '{head: bprq_pkg::NIL_PTR, tail: bprq_pkg::NIL_PTR};
    lvl_clr_en  = 1'b0;
    nrd_addr    = nrd_addr_q;
    nwr_en      = 1'b0;
    nwr_addr    = '0;
    nwr_data    = bprq_pkg::NIL_PTR;
    nclr_en     = 1'b0;
    nclr_addr   = idx_slot;
    q_set_en    = 1'b0;
    q_clr_en    = 1'b0;
    q_addr      = idx_slot;
    mask_set_en = 1'b0;
    mask_clr_en = 1'b0;
    mask_addr   = lvl_addr;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d        = bprq_pkg::req_e'(req_type_i);
          idx_d        = task_index_i;
          lvl_d        = priority_req_i;
          lrd_addr     = bprq_pkg::LVL_AW'(priority_req_i);
          w_d          = bprq_pkg::WORD_W'(bprq_pkg::MASK_WORDS - 1);
          res_status_d = bprq_pkg::STAT_OK;
          res_picked_d = '0;
          res_top_d    = '0;
          if (bprq_pkg::req_e'(req_type_i) == bprq_pkg::REQ_ENQ ||
              bprq_pkg::req_e'(req_type_i) == bprq_pkg::REQ_REM) begin
            state_d = S_HT;
          end else begin
            state_d = S_SRCH;
          end
        end
      end

      S_HT: begin
        if (req_q == bprq_pkg::REQ_ENQ) begin
          state_d = S_DONE;
          if (bad_req || queued_q[idx_slot]) begin
            res_status_d = bprq_pkg::STAT_IGNORED;
          end else begin
            q_set_en = 1'b1;
            nclr_en  = 1'b1;
            lwr_en   = 1'b1;
            if (ht_eff.head == bprq_pkg::NIL_PTR) begin
              lwr_ent     = '{head: idx_ptr, tail: idx_ptr};
              mask_set_en = 1'b1;
            end else begin
              lwr_ent = '{head: ht_eff.head, tail: idx_ptr};
              if (ht_eff.tail != bprq_pkg::NIL_PTR) begin
                nwr_en   = 1'b1;
                nwr_addr = bprq_pkg::SLOT_AW'(ht_eff.tail);
                nwr_data = idx_ptr;
              end
            end
          end
        end else begin
          if (bad_req || !queued_q[idx_slot]) begin
            res_status_d = bprq_pkg::STAT_IGNORED;
            state_d      = S_DONE;
          end else begin
            head_d  = ht_eff.head;
            tail_d  = ht_eff.tail;
            cur_d   = ht_eff.head;
            prev_d  = bprq_pkg::NIL_PTR;
            steps_d = '0;
            state_d = S_WALK_CHK;
          end
        end
      end

      S_WALK_CHK: begin
        if (cur_q == idx_ptr) begin
          nrd_addr = idx_slot;
          state_d  = S_RM_NXT;
        end else if (cur_q == bprq_pkg::NIL_PTR ||
                     steps_q == bprq_pkg::STEP_W'(bprq_pkg::TASK_SLOTS)) begin
          // Not on this level: drop the queued flag only.
          q_clr_en = 1'b1;
          state_d  = S_DONE;
        end else begin
          nrd_addr = bprq_pkg::SLOT_AW'(cur_q);
          prev_d   = cur_q;
          steps_d  = steps_q + 1'b1;
          state_d  = S_WALK_RD;
        end
      end

      S_WALK_RD: begin
        cur_d   = nxt_eff;
        state_d = S_WALK_CHK;
      end

      S_RM_NXT: begin
        // Unlink: nxt_eff holds the link of the removed slot.
        if (prev_q != bprq_pkg::NIL_PTR) begin
          nwr_en   = 1'b1;
          nwr_addr = bprq_pkg::SLOT_AW'(prev_q);
          nwr_data = nxt_eff;
        end
        lwr_en  = 1'b1;
        lwr_ent = '{head: new_head, tail: (tail_q == idx_ptr) ? prev_q : tail_q};
        if (new_head == bprq_pkg::NIL_PTR) begin
          mask_clr_en = 1'b1;
        end
        nclr_en  = 1'b1;
        q_clr_en = 1'b1;
        state_d  = S_DONE;
      end

      S_SRCH: begin
        if (scan_word != '0) begin
          best_d    = scan_lvl;
          res_top_d = bprq_pkg::PRIORITY_REQ_W'(scan_lvl);
          if (req_q == bprq_pkg::REQ_DEQ) begin
            lrd_addr = scan_lvl;
            state_d  = S_DQ_HT;
          end else begin
            state_d = S_DONE;
          end
        end else if (w_q == '0) begin
          res_status_d = bprq_pkg::STAT_EMPTY;
          state_d      = S_DONE;
        end else begin
          w_d = w_q - 1'b1;
        end
      end

      S_DQ_HT: begin
        if (ht_eff.head == bprq_pkg::NIL_PTR) begin
          // Stale mark: empty the level and report it empty.
          lvl_clr_en   = 1'b1;
          lwr_addr     = best_q;
          mask_clr_en  = 1'b1;
          mask_addr    = best_q;
          res_status_d = bprq_pkg::STAT_EMPTY;
          state_d      = S_DONE;
        end else begin
          head_d   = ht_eff.head;
          tail_d   = ht_eff.tail;
          nrd_addr = bprq_pkg::SLOT_AW'(ht_eff.head);
          state_d  = S_DQ_NXT;
        end
      end

      S_DQ_NXT: begin
        lwr_en   = 1'b1;
        lwr_addr = best_q;
        if (nxt_eff == bprq_pkg::NIL_PTR) begin
          lwr_ent     = '{head: bprq_pkg::NIL_PTR, tail: bprq_pkg::NIL_PTR};
          mask_clr_en = 1'b1;
          mask_addr   = best_q;
        end else begin
          lwr_ent = '{head: nxt_eff, tail: tail_q};
        end
        q_clr_en     = 1'b1;
        q_addr       = bprq_pkg::SLOT_AW'(head_q);
        nclr_en      = 1'b1;
        nclr_addr    = bprq_pkg::SLOT_AW'(head_q);
        res_picked_d = bprq_pkg::TASK_INDEX_W'(head_q);
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Set after clear: a slot linked to itself keeps its link.
  always_comb begin
    nxt_vld_d = nxt_vld_q;
    if (nclr_en) begin
      nxt_vld_d[nclr_addr] = 1'b0;
    end
    if (nwr_en) begin
      nxt_vld_d[nwr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
      lvl_vld_q   <= '0;
      nxt_vld_q   <= '0;
      queued_q    <= '0;
      mask_q      <= '0;
    end else begin
      state_q     <= state_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
      nxt_vld_q   <= nxt_vld_d;
      if (lvl_clr_en) begin
        lvl_vld_q[lwr_addr] <= 1'b0;
      end
      if (lwr_en) begin
        lvl_vld_q[lwr_addr] <= 1'b1;
      end
      if (q_set_en) begin
        queued_q[q_addr] <= 1'b1;
      end
      if (q_clr_en) begin
        queued_q[q_addr] <= 1'b0;
      end
      if (mask_set_en) begin
        mask_q[mask_addr] <= 1'b1;
      end
      if (mask_clr_en) begin
        mask_q[mask_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    idx_q        <= idx_d;
    lvl_q        <= lvl_d;
    head_q       <= head_d;
    tail_q       <= tail_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    w_q          <= w_d;
    best_q       <= best_d;
    res_status_q <= res_status_d;
    res_picked_q <= res_picked_d;
    res_top_q    <= res_top_d;
    lrd_addr_q   <= lrd_addr;
    nrd_addr_q   <= nrd_addr;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_picked_q <= res_picked_q;
      out_top_q    <= res_top_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign picked_index_o = out_picked_q;
  assign top_priority_o = out_top_q;

`ifndef SYNTHESIS
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("result word not loaded on leaving the done state");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= bprq_pkg::STEP_W'(bprq_pkg::TASK_SLOTS))
    else $error("list walk ran past the slot count");

  a_prev_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_CHK && prev_q != bprq_pkg::NIL_PTR) |-> (prev_q != idx_ptr))
    else $error("walk predecessor equals the slot being removed");

  a_picked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != bprq_pkg::STAT_OK) |-> (out_picked_q == '0))
    else $error("picked index set on a result that is not done");
`endif

endmodule
